### src/rsi_pkg.sv
`default_nettype none
package rsi_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 62;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = 3'd4;

   localparam logic [61:0] RADIUS_SQR_RST = 62'h0000_0001_0000_0000;
   localparam logic [15:0] EPSILON_RST    = 16'd1;

   // datapath widths
   localparam int A_W     = 64;   // a = D.D, unsigned Q32.32
   localparam int H_W     = 67;   // h = oc.D, signed Q32.32
   localparam int DISC_RW = 132;  // radicand width (disc is never above 2^131)
   localparam int ROOT_W  = DISC_RW / 2;
   localparam int NUM_W   = 69;   // -h +/- sqrt(disc), signed
   localparam int QUO_W   = 31;   // accepted roots are below 2^31

   // sideband alongside the square root
   typedef struct packed {
      logic [H_W-1:0] h;
      logic [A_W-1:0] a;
      logic           miss;
      logic [31:0]    t_min;
      logic [31:0]    t_max;
   } sqrt_side_type;

   // sideband alongside the near-root divider
   typedef struct packed {
      logic        ok_far;
      logic        ok_near;
      logic [31:0] t_min;
      logic [31:0] t_max;
   } div_side_type;

endpackage
`default_nettype wire

### src/rsi_mul.sv
`default_nettype none
// Unsigned multiplier cut into 32x32 partial products, three register stages
module rsi_mul #(
   parameter int AW = 64,
   parameter int BW = 64
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic      [AW+BW-1:0] p
);
   localparam int NA = (AW + 31) / 32;
   localparam int NB = (BW + 31) / 32;
   localparam int RW = 32 * (NB + 1);
   localparam int PW = 32 * (NA + NB);

   logic [NA*32-1:0] a_ext;
   logic [NB*32-1:0] b_ext;
   logic [63:0]      pp_ff  [NA][NB];
   logic [RW-1:0]    row_in [NA];
   logic [RW-1:0]    row_ff [NA];
   logic [PW-1:0]    p_in;
   logic [AW+BW-1:0] p_ff;

   assign a_ext = (NA*32)'(a);
   assign b_ext = (NB*32)'(b);

   // partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
            end
         end
      end
   end

   // one row per chunk of a
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (32 * j));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff <= row_in;
      end
   end

   // final sum of rows
   always_comb begin
      p_in = '0;
      for (int i = 0; i < NA; i++) begin
         p_in = p_in + (PW'(row_ff[i]) << (32 * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in[AW+BW-1:0];
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

### src/rsi_sqrt.sv
`default_nettype none
// Pipelined integer square root, one root bit per stage
module rsi_sqrt #(
   parameter int RW = 132,
   parameter int SW = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [RW-1:0]     in_rad,
   input  wire logic [SW-1:0]     in_side,
   output logic                   out_valid,
   output logic      [RW/2-1:0]   out_root,
   output logic      [SW-1:0]     out_side
);
   localparam int QW = RW / 2;
   localparam int MW = QW + 2;

   logic          v_ff    [QW];
   logic [RW-1:0] rad_ff  [QW];
   logic [MW-1:0] rem_ff  [QW];
   logic [QW-1:0] root_ff [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          cv;
      logic [RW-1:0] crad;
      logic [MW-1:0] crem;
      logic [QW-1:0] croot;
      logic [SW-1:0] cside;
      logic [MW+1:0] rem2;
      logic [MW+1:0] trial;
      logic [MW+1:0] diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign cv    = in_valid;
         assign crad  = in_rad;
         assign crem  = '0;
         assign croot = '0;
         assign cside = in_side;
      end else begin : g_next
         assign cv    = v_ff[s-1];
         assign crad  = rad_ff[s-1];
         assign crem  = rem_ff[s-1];
         assign croot = root_ff[s-1];
         assign cside = side_ff[s-1];
      end

      // bring down two radicand bits, try root*4+1
      assign rem2  = {crem, crad[RW-1 -: 2]};
      assign trial = (MW+2)'({croot, 2'b01});
      assign ge    = rem2 >= trial;
      assign diff  = rem2 - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= cv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= crad << 2;
            rem_ff[s]  <= ge ? diff[MW-1:0] : rem2[MW-1:0];
            root_ff[s] <= {croot[QW-2:0], ge};
            side_ff[s] <= cside;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_root  = root_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule
`default_nettype wire

### src/rsi_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The partial remainder enters already reduced below the divisor.
module rsi_div #(
   parameter int DW = 64,
   parameter int QW = 31,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [QW-1:0] in_low,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic      [QW-1:0] out_quo,
   output logic      [SW-1:0] out_side
);
   logic          v_ff    [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          cv;
      logic [DW-1:0] crem;
      logic [QW-1:0] clow;
      logic [DW-1:0] cden;
      logic [QW-1:0] cquo;
      logic [SW-1:0] cside;
      logic [DW:0]   r2;
      logic [DW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign cv    = in_valid;
         assign crem  = in_rem;
         assign clow  = in_low;
         assign cden  = in_den;
         assign cquo  = '0;
         assign cside = in_side;
      end else begin : g_next
         assign cv    = v_ff[s-1];
         assign crem  = rem_ff[s-1];
         assign clow  = low_ff[s-1];
         assign cden  = den_ff[s-1];
         assign cquo  = quo_ff[s-1];
         assign cside = side_ff[s-1];
      end

      assign r2   = {crem, clow[QW-1]};
      assign ge   = r2 >= {1'b0, cden};
      assign diff = r2 - {1'b0, cden};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= cv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
            low_ff[s]  <= clow << 1;
            den_ff[s]  <= cden;
            quo_ff[s]  <= {cquo[QW-2:0], ge};
            side_ff[s] <= cside;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule
`default_nettype wire

### src/ray_sphere_intersect_core.sv
// Ray against sphere test in signed Q16.16. One ray enters per clock while the
// pipeline is not stalled. Four stages form oc, a, h and c, a 3-stage
// split multiplier forms h*h and a*c, one stage the discriminant, 66 stages
// the integer square root (one root bit each), two stages the root
// numerators and range checks, and 31 stages two dividers working side by
// side on the nearer and farther root, then the result register. The whole
// pipeline advances together whenever the result register is empty or being
// taken; rsp_stall holds every stage and stalls the request side.
// Configuration is read live and must only change while the pipeline is empty.
`default_nettype none
module ray_sphere_intersect_core
   import rsi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // ray request
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_origin_x,
   input  wire logic signed [31:0]    req_origin_y,
   input  wire logic signed [31:0]    req_origin_z,
   input  wire logic signed [31:0]    req_dir_x,
   input  wire logic signed [31:0]    req_dir_y,
   input  wire logic signed [31:0]    req_dir_z,
   input  wire logic signed [31:0]    req_t_min,
   input  wire logic signed [31:0]    req_t_max,
   // result
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic signed [31:0]         rsp_hit_t
);

   logic en;

   // ------------------------------------------------------------------
   // configuration registers
   logic [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [61:0] radius_sqr_ff;
   logic [15:0] epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         center_z_ff   <= '0;
         radius_sqr_ff <= RADIUS_SQR_RST;
         epsilon_ff    <= EPSILON_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_x_ff   <= csr_wdata[31:0];
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata[31:0];
            CSR_CENTER_Z:   center_z_ff   <= csr_wdata[31:0];
            CSR_RADIUS_SQR: radius_sqr_ff <= csr_wdata[61:0];
            CSR_EPSILON:    epsilon_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // global advance: result register free or being taken
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ------------------------------------------------------------------
   // stage 1: oc = origin - centre
   logic               v1_ff;
   logic signed [32:0] ocx1_ff, ocy1_ff, ocz1_ff;
   logic signed [31:0] dx1_ff, dy1_ff, dz1_ff;
   logic [31:0]        tmin1_ff, tmax1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ocx1_ff  <= {req_origin_x[31], req_origin_x} - {center_x_ff[31], center_x_ff};
         ocy1_ff  <= {req_origin_y[31], req_origin_y} - {center_y_ff[31], center_y_ff};
         ocz1_ff  <= {req_origin_z[31], req_origin_z} - {center_z_ff[31], center_z_ff};
         dx1_ff   <= req_dir_x;
         dy1_ff   <= req_dir_y;
         dz1_ff   <= req_dir_z;
         tmin1_ff <= req_t_min;
         tmax1_ff <= req_t_max;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: component products
   logic               v2_ff;
   logic signed [63:0] ddx2_ff, ddy2_ff, ddz2_ff;
   logic signed [64:0] odx2_ff, ody2_ff, odz2_ff;
   logic signed [65:0] oox2_ff, ooy2_ff, ooz2_ff;
   logic [31:0]        tmin2_ff, tmax2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ddx2_ff  <= dx1_ff * dx1_ff;
         ddy2_ff  <= dy1_ff * dy1_ff;
         ddz2_ff  <= dz1_ff * dz1_ff;
         odx2_ff  <= ocx1_ff * dx1_ff;
         ody2_ff  <= ocy1_ff * dy1_ff;
         odz2_ff  <= ocz1_ff * dz1_ff;
         oox2_ff  <= ocx1_ff * ocx1_ff;
         ooy2_ff  <= ocy1_ff * ocy1_ff;
         ooz2_ff  <= ocz1_ff * ocz1_ff;
         tmin2_ff <= tmin1_ff;
         tmax2_ff <= tmax1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: a, h, c
   logic                  v3_ff;
   logic [A_W-1:0]        a3_ff;
   logic signed [H_W-1:0] h3_ff;
   logic signed [67:0]    c3_ff;
   logic [31:0]           tmin3_ff, tmax3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff    <= ddx2_ff[63:0] + ddy2_ff[63:0] + ddz2_ff[63:0];
         h3_ff    <= H_W'(odx2_ff) + H_W'(ody2_ff) + H_W'(odz2_ff);
         c3_ff    <= 68'(oox2_ff) + 68'(ooy2_ff) + 68'(ooz2_ff)
                     - $signed({6'b0, radius_sqr_ff});
         tmin3_ff <= tmin2_ff;
         tmax3_ff <= tmax2_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: magnitudes for the wide products
   logic           v4_ff;
   logic [65:0]    hmag4_ff;
   logic [66:0]    cmag4_ff;
   logic           cneg4_ff;
   sqrt_side_type  side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hmag4_ff       <= h3_ff[H_W-1] ? 66'(-h3_ff) : 66'(h3_ff);
         cmag4_ff       <= c3_ff[67] ? 67'(-c3_ff) : 67'(c3_ff);
         cneg4_ff       <= c3_ff[67];
         side4_ff.h     <= h3_ff;
         side4_ff.a     <= a3_ff;
         side4_ff.miss  <= (a3_ff == '0);
         side4_ff.t_min <= tmin3_ff;
         side4_ff.t_max <= tmax3_ff;
      end
   end

   // ------------------------------------------------------------------
   // stages 5-7: h*h and a*|c|
   logic [131:0] hh;
   logic [130:0] ac;

   rsi_mul #(.AW(66), .BW(66)) u_mul_hh (
      .clock (clock),
      .en    (en),
      .a     (hmag4_ff),
      .b     (hmag4_ff),
      .p     (hh)
   );

   rsi_mul #(.AW(A_W), .BW(67)) u_mul_ac (
      .clock (clock),
      .en    (en),
      .a     (side4_ff.a),
      .b     (cmag4_ff),
      .p     (ac)
   );

   logic          dl_v_ff    [3];
   logic          dl_cneg_ff [3];
   sqrt_side_type dl_side_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_v_ff <= '{default: 1'b0};
      end else if (en) begin
         dl_v_ff[0] <= v4_ff;
         dl_v_ff[1] <= dl_v_ff[0];
         dl_v_ff[2] <= dl_v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_cneg_ff[0] <= cneg4_ff;
         dl_cneg_ff[1] <= dl_cneg_ff[0];
         dl_cneg_ff[2] <= dl_cneg_ff[1];
         dl_side_ff[0] <= side4_ff;
         dl_side_ff[1] <= dl_side_ff[0];
         dl_side_ff[2] <= dl_side_ff[1];
      end
   end

   // ------------------------------------------------------------------
   // stage 8: discriminant h*h - a*c
   logic [132:0]  disc_in;
   logic          v8_ff;
   logic [132:0]  disc8_ff;
   sqrt_side_type side8_in;
   sqrt_side_type side8_ff;

   assign disc_in = dl_cneg_ff[2] ? ({1'b0, hh} + {2'b0, ac})
                                  : ({1'b0, hh} - {2'b0, ac});

   // a negative discriminant joins the miss flag
   always_comb begin
      side8_in      = dl_side_ff[2];
      side8_in.miss = dl_side_ff[2].miss | disc_in[132];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= dl_v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         disc8_ff <= disc_in;
         side8_ff <= side8_in;
      end
   end

   // ------------------------------------------------------------------
   // square root
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sqrt_side_type     sq_side;

   rsi_sqrt #(.RW(DISC_RW), .SW($bits(sqrt_side_type))) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_rad    (disc8_ff[DISC_RW-1:0]),
      .in_side   (side8_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ------------------------------------------------------------------
   // numerators -h - e and -h + e
   logic signed [NUM_W-1:0] neg_h, root_x;
   logic                    vn_ff;
   logic signed [NUM_W-1:0] nnear_ff, nfar_ff;
   logic [A_W-1:0]          an_ff;
   logic                    missn_ff;
   logic [31:0]             tminn_ff, tmaxn_ff;

   assign neg_h  = -NUM_W'($signed(sq_side.h));
   assign root_x = $signed({3'b000, sq_root});

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (en) begin
         vn_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nnear_ff <= neg_h - root_x;
         nfar_ff  <= neg_h + root_x;
         an_ff    <= sq_side.a;
         missn_ff <= sq_side.miss;
         tminn_ff <= sq_side.t_min;
         tmaxn_ff <= sq_side.t_max;
      end
   end

   // ------------------------------------------------------------------
   // range checks: root must be positive and below 2^31 (num < a * 2^15)
   logic              okn_near, okn_far;
   logic              vd_ff;
   logic [A_W-1:0]    ad_ff;
   logic [A_W-1:0]    rem_near_ff, rem_far_ff;
   logic [QUO_W-1:0]  low_near_ff, low_far_ff;
   div_side_type      sided_ff;

   assign okn_near = !missn_ff && !nnear_ff[NUM_W-1] && (nnear_ff != '0)
                     && (79'(nnear_ff[NUM_W-2:0]) < {an_ff, 15'b0});
   assign okn_far  = !missn_ff && !nfar_ff[NUM_W-1] && (nfar_ff != '0)
                     && (79'(nfar_ff[NUM_W-2:0]) < {an_ff, 15'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= vn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff            <= an_ff;
         rem_near_ff      <= A_W'(nnear_ff[NUM_W-2:15]);
         rem_far_ff       <= A_W'(nfar_ff[NUM_W-2:15]);
         low_near_ff      <= {nnear_ff[14:0], 16'b0};
         low_far_ff       <= {nfar_ff[14:0], 16'b0};
         sided_ff.ok_near <= okn_near;
         sided_ff.ok_far  <= okn_far;
         sided_ff.t_min   <= tminn_ff;
         sided_ff.t_max   <= tmaxn_ff;
      end
   end

   // ------------------------------------------------------------------
   // (num * 2^16) / a for both roots
   logic             dv_valid;
   logic [QUO_W-1:0] q_near, q_far;
   div_side_type     dv_side;

   rsi_div #(.DW(A_W), .QW(QUO_W), .SW($bits(div_side_type))) u_div_near (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vd_ff),
      .in_rem    (rem_near_ff),
      .in_low    (low_near_ff),
      .in_den    (ad_ff),
      .in_side   (sided_ff),
      .out_valid (dv_valid),
      .out_quo   (q_near),
      .out_side  (dv_side)
   );

   rsi_div #(.DW(A_W), .QW(QUO_W), .SW(1)) u_div_far (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vd_ff),
      .in_rem    (rem_far_ff),
      .in_low    (low_far_ff),
      .in_den    (ad_ff),
      .in_side   (1'b0),
      .out_valid (),
      .out_quo   (q_far),
      .out_side  ()
   );

   // ------------------------------------------------------------------
   // window test, nearer root first; result register
   logic signed [31:0] tn, tf, eps_s;
   logic               take_near, take_far;
   logic               rsp_valid_ff, rsp_hit_ff;
   logic signed [31:0] rsp_hit_t_ff;

   assign tn    = $signed({1'b0, q_near});
   assign tf    = $signed({1'b0, q_far});
   assign eps_s = $signed({16'b0, epsilon_ff});

   assign take_near = dv_side.ok_near && (tn > eps_s)
                      && (tn > $signed(dv_side.t_min)) && (tn < $signed(dv_side.t_max));
   assign take_far  = dv_side.ok_far && (tf > eps_s)
                      && (tf > $signed(dv_side.t_min)) && (tf < $signed(dv_side.t_max));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= take_near || take_far;
         priority if (take_near) begin
            rsp_hit_t_ff <= tn;
         end else if (take_far) begin
            rsp_hit_t_ff <= tf;
         end else begin
            rsp_hit_t_ff <= $signed(dv_side.t_max);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_t = rsp_hit_t_ff;

endmodule
`default_nettype wire
